>>> design/chi_pkg.sv
package chi_pkg;

    localparam int KNOTS      = 64;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_EVAL = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [0:0] REG_KNOT_COUNT = 1'b0;
    localparam logic [0:0] REG_EST_SLOPES = 1'b1;

    typedef struct packed {
        logic [0:0]         op;
        logic [5:0]         knot_index;
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic signed [31:0] knot_slope;
        logic signed [31:0] eval_point;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] slope_out;
        logic signed [31:0] curvature_out;
        logic [5:0]         interval;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef enum logic [5:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_RD_X0,
        S_RD_X1,
        S_CHK_H,
        S_P_RD0,
        S_P_RD1,
        S_P_RD2,
        S_P_CHK,
        S_P_S01,
        S_P_S12,
        S_P_F0,
        S_P_F2,
        S_P_DONE,
        S_D_RD0,
        S_D_RD1,
        S_WB0,
        S_WB1,
        S_RD_Y,
        S_DIV_S,
        S_DIV_A,
        S_DIV_B1,
        S_DIV_B2,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [35:0] num;
        logic signed [35:0] den;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

>>> design/chi_div.sv
module chi_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chi_pkg::t_div_req    i_req,
    output logic                 o_done,
    output logic signed [31:0]   o_quot
);
    import chi_pkg::*;

    localparam int NW = 36 + FRAC_BITS;
    localparam int QW = NW;

    t_div_state        r_state, n_state;
    logic [NW-1:0]     r_num;
    logic [35:0]       r_den;
    logic [NW:0]       r_rem;
    logic [QW-1:0]     r_q;
    logic [5:0]        r_cnt;
    logic              r_neg;
    logic [NW:0]       w_trial;
    logic [QW:0]       w_qr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_req.start) n_state = DIV_RUN;
            DIV_RUN:  if (r_cnt == 6'd0) n_state = DIV_DONE;
            DIV_DONE: n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= DIV_IDLE;
        else r_state <= n_state;
    end

    assign w_trial = {r_rem[NW-1:0], r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DIV_IDLE: begin
                r_num <= {(i_req.num[35] ? 36'(-i_req.num) : 36'(i_req.num)),
                          {FRAC_BITS{1'b0}}} + NW'((i_req.den[35] ?
                          36'(-i_req.den) : 36'(i_req.den)) >> 1);
                r_den <= i_req.den[35] ? 36'(-i_req.den) : 36'(i_req.den);
                r_neg <= i_req.num[35] ^ i_req.den[35];
                r_rem <= '0;
                r_q   <= '0;
                r_cnt <= 6'(NW - 1);
            end
            DIV_RUN: begin
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 6'd1;
                if (w_trial >= (NW+1)'(r_den)) begin
                    r_rem <= w_trial - (NW+1)'(r_den);
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_qr = r_neg ? -(QW+1)'(r_q) : (QW+1)'(r_q);
        if (r_q > QW'(64'h7FFFFFFF) && !r_neg)
            o_quot = 32'sh7FFFFFFF;
        else if (r_q > QW'(64'h80000000) && r_neg)
            o_quot = 32'sh80000000;
        else
            o_quot = w_qr[31:0];
    end

    assign o_done = (r_state == DIV_DONE);

endmodule

>>> design/cubic_hermite_interpolator.sv
// channel | direction | handshake               | payload
// in      | input     | i_valid/o_stall         | chi_pkg::t_in
// out     | output    | o_valid/i_stall         | chi_pkg::t_out
// cfg     | input     | i_cfg_valid/o_cfg_ready | index, data
// A load writes its knot and completes without a search. An evaluation takes
// the interval search (up to 63 knots), shared serial divides (4, 8 or 12
// of them when no error is found) and six multiply steps.
// Reset clears control state and output valid and resets the config registers;
// data registers and knot stores are not cleared. The next item is taken while
// the last result waits in the output register; a finished result holds until that register drains.
module cubic_hermite_interpolator (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  chi_pkg::t_in     i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output chi_pkg::t_out    o_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    import chi_pkg::*;

    logic signed [31:0] r_xm [KNOTS];
    logic signed [31:0] r_ym [KNOTS];
    logic signed [31:0] r_sm [KNOTS];

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_est;
    t_in              r_in;
    logic [IDX_W-1:0] r_si, w_addr, r_pa;
    logic [1:0]       r_pk;
    logic             r_pboth;
    logic             r_dbusy;
    logic signed [31:0] r_rx, r_ry, r_rs;
    logic signed [31:0] r_x0, r_x1, r_y0, r_d0, r_d1;
    logic signed [31:0] r_px [3];
    logic signed [31:0] r_py [3];
    logic signed [31:0] r_s01, r_s12, r_ds, r_dl, r_dm, r_dr;
    logic signed [31:0] r_sec, r_ca, r_cb, r_dw0, r_dw1, r_t, r_v, r_u;
    logic signed [31:0] r_val, r_sl, r_cv;
    logic [1:0]         r_st;
    t_out               r_out;
    logic               r_ov;
    logic               w_ofree;
    logic               w_we;
    logic [IDX_W-1:0]   w_wa;
    logic signed [31:0] w_wx, w_wy, w_ws;
    logic               w_wx_en;
    t_div_req           w_dreq;
    logic               w_ddone;
    logic signed [31:0] w_dq;
    logic [CNT_W-1:0]   w_n;
    logic               w_take;
    logic               w_fin;
    logic signed [31:0] w_ma, w_mb, w_mr;

    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [63:0] p;
        logic [63:0] r;
        logic        neg;
        p   = (a[31] ? 64'(-33'(a)) : 64'(a)) * (b[31] ? 64'(-33'(b)) : 64'(b));
        r   = (p + 64'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        neg = a[31] ^ b[31];
        if (!neg && r > 64'h7FFFFFFF) return 32'sh7FFFFFFF;
        if (neg && r > 64'h80000000) return 32'sh80000000;
        return neg ? -r[31:0] : r[31:0];
    endfunction

    assign w_n = (r_cnt < CNT_W'(3)) ? CNT_W'(3) :
                 (r_cnt > CNT_W'(KNOTS)) ? CNT_W'(KNOTS) : r_cnt;
    assign o_stall = (r_state != S_IDLE);
    assign w_take  = i_valid && !o_stall;
    assign w_ofree = !r_ov || !i_stall;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_ov && !i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_W'(3);
            r_est <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KNOT_COUNT: r_cnt <= i_cfg_data[CNT_W-1:0];
                REG_EST_SLOPES: r_est <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_we && w_wx_en) begin
            r_xm[w_wa] <= w_wx;
            r_ym[w_wa] <= w_wy;
        end
        if (w_we) r_sm[w_wa] <= w_ws;
        r_rx <= r_xm[w_addr];
        r_ry <= r_ym[w_addr];
        r_rs <= r_sm[w_addr];
    end

    always_comb begin
        w_we = 1'b0; w_wa = r_in.knot_index; w_wx_en = 1'b0;
        w_wx = r_in.knot_x; w_wy = r_in.knot_y; w_ws = r_in.knot_slope;
        if (r_state == S_SRCH_RD && r_in.op == OP_LOAD) begin
            w_we = 1'b1; w_wx_en = 1'b1;
        end else if (r_state == S_WB0) begin
            w_we = 1'b1; w_wa = r_si; w_ws = r_d0;
        end else if (r_state == S_WB1) begin
            w_we = 1'b1; w_wa = r_si + 6'd1; w_ws = r_d1;
        end
    end

    chi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_done (w_ddone),
        .o_quot (w_dq)
    );

    always_comb begin
        w_dreq.start = 1'b0;
        w_dreq.num   = '0;
        w_dreq.den   = '0;
        unique case (r_state)
            S_P_S01: begin
                w_dreq.num = 36'(r_py[1]) - 36'(r_py[0]);
                w_dreq.den = 36'(r_px[1]) - 36'(r_px[0]);
            end
            S_P_S12: begin
                w_dreq.num = 36'(r_py[2]) - 36'(r_py[1]);
                w_dreq.den = 36'(r_px[2]) - 36'(r_px[1]);
            end
            S_P_F0: begin
                w_dreq.num = 36'(r_px[1]) - 36'(r_px[0]);
                w_dreq.den = 36'(r_px[2]) - 36'(r_px[0]);
            end
            S_P_F2: begin
                w_dreq.num = 36'(r_px[2]) - 36'(r_px[1]);
                w_dreq.den = 36'(r_px[2]) - 36'(r_px[0]);
            end
            S_DIV_S: begin
                w_dreq.num = 36'(r_ry) - 36'(r_y0);
                w_dreq.den = 36'(r_x1) - 36'(r_x0);
            end
            S_DIV_A: begin
                w_dreq.num = 36'(r_sec) - 36'(r_d0);
                w_dreq.den = 36'(r_x1) - 36'(r_x0);
            end
            S_DIV_B1: begin
                w_dreq.num = 36'(r_d0) + 36'(r_d1) - 36'(r_sec) - 36'(r_sec);
                w_dreq.den = 36'(r_x1) - 36'(r_x0);
            end
            S_DIV_B2: begin
                w_dreq.num = 36'(r_cb);
                w_dreq.den = 36'(r_x1) - 36'(r_x0);
            end
            default: ;
        endcase
        w_dreq.start = (r_state == S_P_S01 || r_state == S_P_S12 ||
                        r_state == S_P_F0 || r_state == S_P_F2 ||
                        r_state == S_DIV_S || r_state == S_DIV_A ||
                        r_state == S_DIV_B1 || r_state == S_DIV_B2) && !r_dbusy;
    end

    // one shared multiplier, operands chosen per step
    always_comb begin
        w_ma = '0; w_mb = '0;
        unique case (r_state)
            S_P_F0: begin w_ma = r_ds; w_mb = w_dq; end
            S_P_F2: begin w_ma = r_ds; w_mb = w_dq; end
            S_M1: begin w_ma = r_dw1; w_mb = r_cb; end
            S_M2: begin w_ma = r_dw0; w_mb = r_t; end
            S_M3: begin w_ma = r_dw0; w_mb = r_t; end
            S_M4: begin w_ma = r_cb;  w_mb = r_u; end
            S_M5: begin w_ma = r_dw0; w_mb = r_v; end
            S_M6: begin w_ma = r_cb;  w_mb = r_u; end
            default: ;
        endcase
        w_mr = fmul(w_ma, w_mb);
    end

    assign w_fin = w_ddone && r_dbusy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_take) n_state = S_SRCH_RD;
            S_SRCH_RD:  n_state = (r_in.op == OP_LOAD) ? S_OUT : S_SRCH_CHK;
            S_SRCH_CHK: if (r_in.eval_point >= r_rx || r_si == '0)
                            n_state = S_RD_X0;
                        else n_state = S_SRCH_CHK;
            S_RD_X0:    n_state = S_RD_X1;
            S_RD_X1:    n_state = S_CHK_H;
            S_CHK_H:    if (r_rx == r_x0) n_state = S_OUT;
                        else if (r_est) n_state = S_P_RD0;
                        else n_state = S_D_RD0;
            S_P_RD0:    n_state = S_P_RD1;
            S_P_RD1:    n_state = S_P_RD2;
            S_P_RD2:    n_state = S_P_CHK;
            S_P_CHK:    if (r_px[0] == r_px[1] || r_px[1] == r_px[2] ||
                            r_px[0] == r_px[2]) n_state = S_OUT;
                        else n_state = S_P_S01;
            S_P_S01:    if (w_fin) n_state = S_P_S12;
            S_P_S12:    if (w_fin) n_state = S_P_F0;
            S_P_F0:     if (w_fin) n_state = S_P_F2;
            S_P_F2:     if (w_fin) n_state = S_P_DONE;
            S_P_DONE:   n_state = r_pboth ? S_P_RD0 : S_WB0;
            S_D_RD0:    n_state = S_D_RD1;
            S_D_RD1:    n_state = S_RD_Y;
            S_WB0:      n_state = S_WB1;
            S_WB1:      n_state = S_RD_Y;
            S_RD_Y:     n_state = S_DIV_S;
            S_DIV_S:    if (w_fin) n_state = S_DIV_A;
            S_DIV_A:    if (w_fin) n_state = S_DIV_B1;
            S_DIV_B1:   if (w_fin) n_state = S_DIV_B2;
            S_DIV_B2:   if (w_fin) n_state = S_M1;
            S_M1:       n_state = S_M2;
            S_M2:       n_state = S_M3;
            S_M3:       n_state = S_M4;
            S_M4:       n_state = S_M5;
            S_M5:       n_state = S_M6;
            S_M6:       n_state = S_OUT;
            S_OUT:      if (w_ofree) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        w_addr = r_si;
        unique case (r_state)
            S_IDLE:     w_addr = 6'(w_n - CNT_W'(2));
            S_SRCH_CHK: w_addr = (r_in.eval_point >= r_rx || r_si == '0) ? r_si
                                 : r_si - 6'd1;
            S_RD_X0:    w_addr = r_si + 6'd1;
            S_RD_X1:    w_addr = r_si + 6'd1;
            S_CHK_H:    w_addr = r_pa;
            S_P_DONE:   w_addr = r_si;
            S_P_RD0:    w_addr = r_pa + 6'd1;
            S_P_RD1:    w_addr = r_pa + 6'd2;
            S_D_RD1:    w_addr = r_si + 6'd1;
            S_WB1:      w_addr = r_si + 6'd1;
            S_RD_Y:     w_addr = r_si + 6'd1;
            default:    w_addr = r_si;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_dbusy <= 1'b0;
        end else begin
            if (r_state == S_OUT && w_ofree) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (w_ddone) r_dbusy <= 1'b0;
            else if (w_dreq.start) r_dbusy <= 1'b1;
        end
        if (r_state == S_OUT && w_ofree)
            r_out <= '{value: r_val, slope_out: r_sl, curvature_out: r_cv,
                       interval: (r_in.op == OP_LOAD) ? '0 : r_si,
                       status: r_st};
        unique case (r_state)
            S_IDLE: if (w_take) begin
                r_in <= i_data;
                r_si <= 6'(w_n - CNT_W'(2));
                r_val <= '0; r_sl <= '0; r_cv <= '0;
                r_st <= (i_data.op == OP_LOAD) ? ST_LOAD : ST_OK;
            end
            S_SRCH_CHK: if (!(r_in.eval_point >= r_rx || r_si == '0))
                r_si <= r_si - 6'd1;
            S_RD_X0: begin
                r_x0 <= r_rx; r_y0 <= r_ry;
            end
            S_RD_X1: begin
                r_pk <= 2'd0;
                r_pboth <= (r_si != '0) && (CNT_W'(r_si) < w_n - CNT_W'(2));
                if (r_si == '0) r_pa <= '0;
                else r_pa <= r_si - 6'd1;
            end
            S_CHK_H: begin
                r_x1 <= r_rx;
                if (r_rx == r_x0) r_st <= ST_ERR;
            end
            S_P_RD0: begin r_px[0] <= r_rx; r_py[0] <= r_ry; end
            S_P_RD1: begin r_px[1] <= r_rx; r_py[1] <= r_ry; end
            S_P_RD2: begin r_px[2] <= r_rx; r_py[2] <= r_ry; end
            S_P_CHK: begin
                if (r_px[0] == r_px[1] || r_px[1] == r_px[2] ||
                    r_px[0] == r_px[2]) r_st <= ST_ERR;
            end
            S_P_S01: if (w_fin) r_s01 <= w_dq;
            S_P_S12: if (w_fin) begin
                r_s12 <= w_dq;
                r_ds  <= sat32(40'(w_dq) - 40'(r_s01));
            end
            S_P_F0: if (w_fin) begin
                r_dl <= sat32(40'(r_s01) - 40'(w_mr));
                r_dm <= sat32(40'(r_s01) + 40'(w_mr));
            end
            S_P_F2: if (w_fin) r_dr <= sat32(40'(r_s12) + 40'(w_mr));
            S_P_DONE: begin
                if (r_si == '0) begin r_d0 <= r_dl; r_d1 <= r_dm; end
                else if (!r_pboth && r_pk == 2'd0) begin
                    r_d0 <= r_dm; r_d1 <= r_dr;
                end else if (r_pk == 2'd0) r_d0 <= r_dm;
                else r_d1 <= r_dm;
                r_pk <= r_pk + 2'd1;
                r_pa <= r_si;
                r_pboth <= 1'b0;
            end
            S_D_RD1: r_d0 <= r_rs;
            S_RD_Y:  if (!r_est) r_d1 <= r_rs;
            S_DIV_S:  if (w_fin) r_sec <= w_dq;
            S_DIV_A:  if (w_fin) r_ca <= w_dq;
            S_DIV_B1: if (w_fin) r_cb <= w_dq;
            S_DIV_B2: if (w_fin) begin
                r_cb  <= w_dq;
                r_dw0 <= sat32(40'(r_in.eval_point) - 40'(r_x0));
                r_dw1 <= sat32(40'(r_in.eval_point) - 40'(r_x1));
            end
            S_M1: r_t <= sat32(40'(r_ca) + 40'(w_mr));
            S_M2: begin
                r_t <= sat32(40'(r_d0) + 40'(w_mr));
                r_u <= sat32(40'(r_dw0) + 40'(r_dw1) + 40'(r_dw1));
            end
            S_M3: r_val <= sat32(40'(r_y0) + 40'(w_mr));
            S_M4: begin
                r_v <= sat32(40'(r_ca) + 40'(r_ca) + 40'(w_mr));
                r_u <= sat32(40'(r_dw0) + 40'(r_dw0) + 40'(r_dw1));
            end
            S_M5: r_sl <= sat32(40'(r_d0) + 40'(w_mr));
            S_M6: r_cv <= sat32(40'(r_ca) + 40'(r_ca) + 40'(w_mr) + 40'(w_mr));
            default: ;
        endcase
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

>>> design/chi_checker.sv
module chi_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          o_stall,
    input  chi_pkg::t_in  i_data,
    input  logic          o_valid,
    input  logic          i_stall,
    input  chi_pkg::t_out o_data
);
    import chi_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("output changed while stalled");

    a_load_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_LOAD |-> o_data.value == 32'sd0)
        else $error("load result not zero");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status == ST_OK || o_data.status == ST_LOAD ||
                    o_data.status == ST_ERR)
        else $error("bad status");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accepted two items back to back");

endmodule

bind cubic_hermite_interpolator chi_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_stall(o_stall),
    .i_data (i_data),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);
